FILE: rtl/core/rri2d_pkg.sv
// Shared types and widths for the 2D line intersection block.
`default_nettype none
package rri2d_pkg;
    localparam int COORD_W = 16;                // input coordinate width
    localparam int RES_W   = 32;                // result coordinate width
    localparam int D_W     = COORD_W + 1;       // differences
    localparam int PR_W    = 2 * D_W;           // one cross product term
    localparam int P_W     = PR_W + 1;          // det, u_num, v_num
    localparam int M_W     = D_W + P_W;         // direction times u_num
    localparam int S_W     = M_W + 2;           // start plus signed quotient

    typedef struct packed {
        logic signed [COORD_W-1:0] a_start_x;
        logic signed [COORD_W-1:0] a_start_y;
        logic signed [COORD_W-1:0] a_end_x;
        logic signed [COORD_W-1:0] a_end_y;
        logic signed [COORD_W-1:0] b_start_x;
        logic signed [COORD_W-1:0] b_start_y;
        logic signed [COORD_W-1:0] b_end_x;
        logic signed [COORD_W-1:0] b_end_y;
    } t_in;

    typedef struct packed {
        logic signed [RES_W-1:0] hit_x;
        logic signed [RES_W-1:0] hit_y;
        logic                    ahead_of_both;
        logic                    parallel;
        logic                    saturated;
    } t_out;

    // side information that rides alongside the dividers
    typedef struct packed {
        logic signed [COORD_W-1:0] asx;
        logic signed [COORD_W-1:0] asy;
        logic                      neg_x;
        logic                      neg_y;
        logic                      parallel;
        logic                      ahead;
    } t_side;
endpackage
`default_nettype wire

FILE: rtl/core/ray_ray_intersection_2d.sv
// Top level: 2D line intersection by Cramer's rule, fully pipelined.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------
//  input    | i_start, o_busy    | i_item  (t_in)
//  result   | o_valid (strobe)   | o_result (t_out)
//
// One transfer may be started every cycle; o_busy is always low.
// Results pass the input stages, then the two restoring dividers that
// produce one quotient bit per stage, then the output register.
// Synchronous active-low reset clears the valid bits only.
// The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none
module ray_ray_intersection_2d (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire rri2d_pkg::t_in  i_item,
    output logic                 o_busy,
    output logic                 o_valid,
    output rri2d_pkg::t_out      o_result
);
    import rri2d_pkg::*;

    localparam int LAT = M_W + 7;
    localparam logic signed [S_W-1:0] RMAX = {{(S_W-RES_W+1){1'b0}}, {(RES_W-1){1'b1}}};
    localparam logic signed [S_W-1:0] RMIN = ~RMAX;

    // stage 1: differences
    logic                      r_v1;
    logic signed [D_W-1:0]     r_adx, r_ady, r_bdx, r_bdy, r_dx, r_dy;
    logic signed [COORD_W-1:0] r_asx1, r_asy1;
    // stage 2: cross product terms
    logic                      r_v2;
    logic signed [PR_W-1:0]    r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    logic signed [D_W-1:0]     r_adx2, r_ady2;
    logic signed [COORD_W-1:0] r_asx2, r_asy2;
    // stage 3: det, numerators
    logic                      r_v3;
    logic signed [P_W-1:0]     r_det, r_unum, r_vnum;
    logic signed [D_W-1:0]     r_adx3, r_ady3;
    logic signed [COORD_W-1:0] r_asx3, r_asy3;
    // stage 4: direction times u_num, flags
    logic                      r_v4;
    logic signed [M_W-1:0]     r_mx, r_my;
    logic signed [P_W-1:0]     r_det4;
    logic                      r_par4, r_ahead4;
    logic signed [COORD_W-1:0] r_asx4, r_asy4;
    // stage 5: magnitudes and signs
    logic                      r_v5;
    logic [M_W-1:0]            r_nx, r_ny;
    logic [P_W-1:0]            r_dm;
    t_side                     r_side5;
    // alongside the dividers
    logic                      r_vd [0:M_W];
    t_side                     r_sd [0:M_W];
    // output
    logic                      r_valid;
    t_out                      r_out;

    logic [M_W-1:0]        quo_x, quo_y;
    logic signed [S_W-1:0] sum_x, sum_y;
    logic                  non_u, non_v;
    t_side                 side;
    t_out                  n_out;

    assign o_busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            r_v5    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_v1    <= i_start;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            r_v5    <= r_v4;
            r_valid <= r_vd[M_W];
        end
    end

    always_ff @(posedge i_clk) begin
        r_adx  <= D_W'(i_item.a_end_x) - D_W'(i_item.a_start_x);
        r_ady  <= D_W'(i_item.a_end_y) - D_W'(i_item.a_start_y);
        r_bdx  <= D_W'(i_item.b_end_x) - D_W'(i_item.b_start_x);
        r_bdy  <= D_W'(i_item.b_end_y) - D_W'(i_item.b_start_y);
        r_dx   <= D_W'(i_item.b_start_x) - D_W'(i_item.a_start_x);
        r_dy   <= D_W'(i_item.b_start_y) - D_W'(i_item.a_start_y);
        r_asx1 <= i_item.a_start_x;
        r_asy1 <= i_item.a_start_y;

        r_p0   <= r_bdx * r_ady;
        r_p1   <= r_bdy * r_adx;
        r_p2   <= r_dy * r_bdx;
        r_p3   <= r_dx * r_bdy;
        r_p4   <= r_dy * r_adx;
        r_p5   <= r_dx * r_ady;
        r_adx2 <= r_adx;
        r_ady2 <= r_ady;
        r_asx2 <= r_asx1;
        r_asy2 <= r_asy1;

        r_det  <= P_W'(r_p0) - P_W'(r_p1);
        r_unum <= P_W'(r_p2) - P_W'(r_p3);
        r_vnum <= P_W'(r_p4) - P_W'(r_p5);
        r_adx3 <= r_adx2;
        r_ady3 <= r_ady2;
        r_asx3 <= r_asx2;
        r_asy3 <= r_asy2;

        r_mx     <= r_adx3 * r_unum;
        r_my     <= r_ady3 * r_unum;
        r_det4   <= r_det;
        r_par4   <= (r_det == '0);
        r_ahead4 <= non_u && non_v;
        r_asx4   <= r_asx3;
        r_asy4   <= r_asy3;

        r_nx             <= r_mx[M_W-1] ? M_W'(-r_mx) : M_W'(r_mx);
        r_ny             <= r_my[M_W-1] ? M_W'(-r_my) : M_W'(r_my);
        r_dm             <= r_det4[P_W-1] ? P_W'(-r_det4) : P_W'(r_det4);
        r_side5.asx      <= r_asx4;
        r_side5.asy      <= r_asy4;
        r_side5.neg_x    <= r_mx[M_W-1] ^ r_det4[P_W-1];
        r_side5.neg_y    <= r_my[M_W-1] ^ r_det4[P_W-1];
        r_side5.parallel <= r_par4;
        r_side5.ahead    <= r_ahead4;

        r_out <= n_out;
    end

    // a numerator counts as non-negative when zero or of det's sign
    assign non_u = (r_unum == '0) || (r_unum[P_W-1] == r_det[P_W-1]);
    assign non_v = (r_vnum == '0) || (r_vnum[P_W-1] == r_det[P_W-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd[0] <= 1'b0;
        end else begin
            r_vd[0] <= r_v5;
        end
        r_sd[0] <= r_side5;
    end

    for (genvar k = 1; k <= M_W; k++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vd[k] <= 1'b0;
            end else begin
                r_vd[k] <= r_vd[k-1];
            end
            r_sd[k] <= r_sd[k-1];
        end
    end

    rri2d_div u_div_x (
        .i_clk (i_clk),
        .i_num (r_nx),
        .i_den (r_dm),
        .o_quo (quo_x)
    );

    rri2d_div u_div_y (
        .i_clk (i_clk),
        .i_num (r_ny),
        .i_den (r_dm),
        .o_quo (quo_y)
    );

    assign side = r_sd[M_W];

    always_comb begin
        logic signed [M_W:0] qx, qy;
        logic                clip_x, clip_y;
        qx     = side.neg_x ? -$signed({1'b0, quo_x}) : $signed({1'b0, quo_x});
        qy     = side.neg_y ? -$signed({1'b0, quo_y}) : $signed({1'b0, quo_y});
        sum_x  = S_W'(side.asx) + S_W'(qx);
        sum_y  = S_W'(side.asy) + S_W'(qy);
        clip_x = (sum_x > RMAX) || (sum_x < RMIN);
        clip_y = (sum_y > RMAX) || (sum_y < RMIN);

        n_out = '0;
        if (side.parallel) begin
            n_out.parallel = 1'b1;
        end else begin
            n_out.hit_x = (sum_x > RMAX) ? RMAX[RES_W-1:0] :
                          (sum_x < RMIN) ? RMIN[RES_W-1:0] : sum_x[RES_W-1:0];
            n_out.hit_y = (sum_y > RMAX) ? RMAX[RES_W-1:0] :
                          (sum_y < RMIN) ? RMIN[RES_W-1:0] : sum_y[RES_W-1:0];
            n_out.ahead_of_both = side.ahead;
            n_out.saturated     = clip_x || clip_y;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_out;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##LAT 1'b1 |-> (o_valid == $past(i_start, LAT)))
        else $error("result strobe out of step with start");

    a_par_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.parallel |->
        (o_result.hit_x == '0) && (o_result.hit_y == '0)
        && !o_result.saturated && !o_result.ahead_of_both)
        else $error("parallel result carries data");

    a_sat_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.saturated |->
        (o_result.hit_x == RMAX[RES_W-1:0]) || (o_result.hit_x == RMIN[RES_W-1:0])
        || (o_result.hit_y == RMAX[RES_W-1:0]) || (o_result.hit_y == RMIN[RES_W-1:0]))
        else $error("saturated flag without a clipped coordinate");

    a_det_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |-> (r_par4 == (r_det4 == '0)))
        else $error("parallel flag disagrees with det");
endmodule
`default_nettype wire

FILE: rtl/core/rri2d_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
`default_nettype none
module rri2d_div (
    input  wire logic                      i_clk,
    input  wire logic [rri2d_pkg::M_W-1:0] i_num,
    input  wire logic [rri2d_pkg::P_W-1:0] i_den,
    output logic      [rri2d_pkg::M_W-1:0] o_quo
);
    import rri2d_pkg::*;

    logic [P_W-1:0] r_rem [0:M_W];
    logic [M_W-1:0] r_num [0:M_W];
    logic [P_W-1:0] r_den [0:M_W];
    logic [M_W-1:0] r_quo [0:M_W];

    always_ff @(posedge i_clk) begin
        r_rem[0] <= '0;
        r_num[0] <= i_num;
        r_den[0] <= i_den;
        r_quo[0] <= '0;
    end

    for (genvar k = 0; k < M_W; k++) begin : g_stage
        logic [P_W:0] trial;
        logic [P_W:0] diff;
        logic         fits;
        assign trial = {r_rem[k], r_num[k][M_W-1]};
        assign diff  = trial - {1'b0, r_den[k]};
        assign fits  = (trial >= {1'b0, r_den[k]});

        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= fits ? diff[P_W-1:0] : trial[P_W-1:0];
            r_num[k+1] <= {r_num[k][M_W-2:0], 1'b0};
            r_den[k+1] <= r_den[k];
            r_quo[k+1] <= {r_quo[k][M_W-2:0], fits};
        end
    end

    assign o_quo = r_quo[M_W];
endmodule
`default_nettype wire
